@@ src/tmcp_pkg.sv @@
package tmcp_pkg;

   localparam int unsigned CODE_W   = 8;
   localparam int unsigned HEIGHT_W = 5;
   localparam int unsigned TABS_W   = 4;
   localparam int unsigned ESC_W    = 2;

   localparam int unsigned MAX_TABS_DEFAULT = 15;
   localparam int unsigned TAB_LIMIT        = 15;

   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 5'd8;
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = 5'd29;
   localparam logic [3:0]          DIGIT_TWO_MAX = 4'd2;

   localparam logic [CODE_W-1:0] CHAR_NUL       = 8'h00;
   localparam logic [CODE_W-1:0] CHAR_TEXT_LOW  = 8'h06;
   localparam logic [CODE_W-1:0] CHAR_SPACE     = 8'h20;
   localparam logic [CODE_W-1:0] CHAR_BS        = 8'h08;
   localparam logic [CODE_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CODE_W-1:0] CHAR_VT        = 8'h0B;
   localparam logic [CODE_W-1:0] CHAR_FF        = 8'h0C;
   localparam logic [CODE_W-1:0] CHAR_ZERO      = 8'h30;
   localparam logic [CODE_W-1:0] CHAR_NINE      = 8'h39;
   localparam logic [CODE_W-1:0] CHAR_LOWER_B   = 8'h62;
   localparam logic [CODE_W-1:0] CHAR_LOWER_V   = 8'h76;

   localparam logic [ESC_W-1:0] ESC_NONE  = 2'd0;
   localparam logic [ESC_W-1:0] ESC_OPEN  = 2'd1;
   localparam logic [ESC_W-1:0] ESC_DIGIT = 2'd2;

   typedef struct packed {
      logic                is_line_end;
      logic [CODE_W-1:0]   out_code;
      logic                chunk_start;
      logic [HEIGHT_W-1:0] out_height;
      logic                out_bold;
      logic                out_inverse;
      logic [TABS_W-1:0]   out_tabs;
   } result_type;

endpackage

@@ src/tmcp_core.sv @@
module tmcp_core #(
   parameter int unsigned MAX_TABS = tmcp_pkg::MAX_TABS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [tmcp_pkg::CODE_W-1:0]     code,
   input  logic [tmcp_pkg::HEIGHT_W-1:0]   default_height,
   output logic                            res_valid,
   output tmcp_pkg::result_type            res
);
   import tmcp_pkg::*;

   localparam int unsigned TabCapInt = (MAX_TABS > TAB_LIMIT) ? TAB_LIMIT : MAX_TABS;
   localparam logic [TABS_W-1:0] TabCap = TabCapInt[TABS_W-1:0];

   logic                bold_ff, bold_in;
   logic                inv_ff, inv_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [TABS_W-1:0]   tab_ff, tab_in;
   logic [ESC_W-1:0]    esc_ff, esc_in;
   logic                run_ff, run_in;

   logic                consumed;
   logic                is_digit;
   logic [3:0]          digit_val;
   logic [CODE_W-1:0]   digit_diff;
   logic [7:0]          two_digit;

   assign is_digit   = code inside {[CHAR_ZERO:CHAR_NINE]};
   assign digit_diff = code - CHAR_ZERO;
   assign digit_val  = digit_diff[3:0];
   assign two_digit  = {3'b000, height_ff} * 8'd10 + {4'b0000, digit_val};

   always_comb begin
      consumed  = 1'b0;
      bold_in   = bold_ff;
      inv_in    = inv_ff;
      height_in = height_ff;
      tab_in    = tab_ff;
      esc_in    = ESC_NONE;
      run_in    = run_ff;
      res_valid = 1'b0;
      res.is_line_end = 1'b0;
      res.out_code    = code;
      res.chunk_start = 1'b1;
      res.out_height  = height_ff;
      res.out_bold    = bold_ff;
      res.out_inverse = inv_ff;
      res.out_tabs    = tab_ff;

      case (esc_ff)
         ESC_OPEN: begin
            if (is_digit) begin
               consumed  = 1'b1;
               height_in = {1'b0, digit_val};
               if (digit_val <= DIGIT_TWO_MAX) begin
                  esc_in = ESC_DIGIT;
               end
            end else if (code == CHAR_LOWER_B) begin
               consumed = 1'b1;
               bold_in  = ~bold_ff;
            end else if (code == CHAR_LOWER_V) begin
               consumed = 1'b1;
               inv_in   = ~inv_ff;
            end
         end
         ESC_DIGIT: begin
            if (is_digit) begin
               consumed  = 1'b1;
               height_in = two_digit[HEIGHT_W-1:0];
            end
         end
         default: begin
         end
      endcase

      if (!consumed) begin
         if (code == CHAR_NUL) begin
            res_valid       = 1'b1;
            res.is_line_end = 1'b1;
            res.chunk_start = 1'b0;
            bold_in   = 1'b0;
            inv_in    = 1'b0;
            height_in = default_height;
            tab_in    = '0;
            run_in    = 1'b0;
         end else if (code <= CHAR_TEXT_LOW || code >= CHAR_SPACE) begin
            res_valid       = 1'b1;
            res.chunk_start = ~run_ff;
            run_in          = 1'b1;
         end else begin
            run_in = 1'b0;
            case (code)
               CHAR_BS:  bold_in = ~bold_ff;
               CHAR_TAB: begin
                  if (tab_ff < TabCap) begin
                     tab_in = tab_ff + TABS_W'(1);
                  end
               end
               CHAR_VT:  inv_in = ~inv_ff;
               CHAR_FF:  esc_in = ESC_OPEN;
               default:  res_valid = 1'b1;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bold_ff   <= 1'b0;
         inv_ff    <= 1'b0;
         height_ff <= HEIGHT_RESET;
         tab_ff    <= '0;
         esc_ff    <= ESC_NONE;
         run_ff    <= 1'b0;
      end else if (step) begin
         bold_ff   <= bold_in;
         inv_ff    <= inv_in;
         height_ff <= height_in;
         tab_ff    <= tab_in;
         esc_ff    <= esc_in;
         run_ff    <= run_in;
      end
   end

   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && res.is_line_end |=> tab_ff == '0 && !bold_ff && !inv_ff
         && esc_ff == ESC_NONE && !run_ff)
      else $error("state not cleared after line end");

   a_tab_cap: assert property (@(posedge clock) disable iff (reset)
      tab_ff <= TabCap)
      else $error("tab count above cap");

   a_run_continue: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && !res.is_line_end && !res.chunk_start |-> run_ff)
      else $error("chunk continued without open run");

   a_second_digit: assert property (@(posedge clock) disable iff (reset)
      esc_ff == ESC_DIGIT |-> height_ff <= {2'b00, 3'd2})
      else $error("two-digit escape after large first digit");

endmodule

@@ src/tmcp_out.sv @@
module tmcp_out (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  tmcp_pkg::result_type            res,
   output logic                            free,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_is_line_end,
   output logic [tmcp_pkg::CODE_W-1:0]     rsp_out_code,
   output logic                            rsp_chunk_start,
   output logic [tmcp_pkg::HEIGHT_W-1:0]   rsp_out_height,
   output logic                            rsp_out_bold,
   output logic                            rsp_out_inverse,
   output logic [tmcp_pkg::TABS_W-1:0]     rsp_out_tabs
);
   import tmcp_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign free     = ~valid_ff | ~rsp_stall;
   assign valid_in = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_is_line_end = data_ff.is_line_end;
   assign rsp_out_code    = data_ff.out_code;
   assign rsp_chunk_start = data_ff.chunk_start;
   assign rsp_out_height  = data_ff.out_height;
   assign rsp_out_bold    = data_ff.out_bold;
   assign rsp_out_inverse = data_ff.out_inverse;
   assign rsp_out_tabs    = data_ff.out_tabs;

endmodule

@@ src/text_markup_chunk_parser_unit.sv @@
// Path: a byte taken into the input register is decoded once the result register is
//    free; its result transfer is then offered from the result register.
// Throughput: one byte per cycle; the input register and result register each stall
//    only while the result register holds an untaken result.
// Reset: synchronous, active high; attributes, tab count, escape and run clear,
//    height and default height return to 8, both registers empty.
module text_markup_chunk_parser_unit #(
   parameter int unsigned MAX_TABS = tmcp_pkg::MAX_TABS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [tmcp_pkg::CODE_W-1:0]     req_code,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_is_line_end,
   output logic [tmcp_pkg::CODE_W-1:0]     rsp_out_code,
   output logic                            rsp_chunk_start,
   output logic [tmcp_pkg::HEIGHT_W-1:0]   rsp_out_height,
   output logic                            rsp_out_bold,
   output logic                            rsp_out_inverse,
   output logic [tmcp_pkg::TABS_W-1:0]     rsp_out_tabs,
   input  logic                            csr_wr_en,
   input  logic [tmcp_pkg::HEIGHT_W-1:0]   csr_wr_data
);
   import tmcp_pkg::*;

   logic                in_valid_ff, in_valid_in;
   logic [CODE_W-1:0]   in_code_ff;
   logic [HEIGHT_W-1:0] dflt_height_ff, dflt_height_in;
   logic                accept;
   logic                step;
   logic                out_free;
   logic                res_valid;
   result_type          res;

   assign step        = in_valid_ff & out_free;
   assign req_stall   = in_valid_ff & ~out_free;
   assign accept      = req_valid & ~req_stall;
   assign in_valid_in = accept | (in_valid_ff & ~step);

   assign dflt_height_in = (csr_wr_data > HEIGHT_MAX) ? HEIGHT_MAX : csr_wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         dflt_height_ff <= HEIGHT_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) begin
            dflt_height_ff <= dflt_height_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_code_ff <= req_code;
      end
   end

   tmcp_core #(
      .MAX_TABS(MAX_TABS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .code           (in_code_ff),
      .default_height (dflt_height_ff),
      .res_valid      (res_valid),
      .res            (res)
   );

   tmcp_out u_out (
      .clock           (clock),
      .reset           (reset),
      .load            (step & res_valid),
      .res             (res),
      .free            (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_is_line_end (rsp_is_line_end),
      .rsp_out_code    (rsp_out_code),
      .rsp_chunk_start (rsp_chunk_start),
      .rsp_out_height  (rsp_out_height),
      .rsp_out_bold    (rsp_out_bold),
      .rsp_out_inverse (rsp_out_inverse),
      .rsp_out_tabs    (rsp_out_tabs)
   );

endmodule

@@ test/tb_text_markup_chunk_parser_unit.sv @@
module tb_text_markup_chunk_parser_unit;
   import tmcp_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned PHASE_ITEMS = 72;
   localparam int unsigned TAB_CAP     = (MAX_TABS_DEFAULT > TAB_LIMIT) ? TAB_LIMIT
                                                                        : MAX_TABS_DEFAULT;

   class chunk_scoreboard;
      result_type          expected_q[$];
      int unsigned         errors;
      logic                bold_on;
      logic                inverse_on;
      logic [HEIGHT_W-1:0] glyph_height;
      logic [HEIGHT_W-1:0] default_height;
      logic [TABS_W-1:0]   tab_count;
      logic [ESC_W-1:0]    escape_phase;
      logic                in_run;

      function new();
         errors         = 0;
         bold_on        = 1'b0;
         inverse_on     = 1'b0;
         glyph_height   = HEIGHT_RESET;
         default_height = HEIGHT_RESET;
         tab_count      = '0;
         escape_phase   = ESC_NONE;
         in_run         = 1'b0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void set_default_height(input logic [HEIGHT_W-1:0] value);
         default_height = (value > HEIGHT_MAX) ? HEIGHT_MAX : value;
      endfunction

      function void push_result(input logic line_end, input logic [CODE_W-1:0] c,
                                input logic start);
         result_type r;
         r.is_line_end = line_end;
         r.out_code    = c;
         r.chunk_start = start;
         r.out_height  = glyph_height;
         r.out_bold    = bold_on;
         r.out_inverse = inverse_on;
         r.out_tabs    = tab_count;
         expected_q.push_back(r);
      endfunction

      function void note_byte(input logic [CODE_W-1:0] c);
         logic        is_digit;
         logic [31:0] sum;
         is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
         if (escape_phase == ESC_OPEN) begin
            escape_phase = ESC_NONE;
            if (is_digit) begin
               sum          = 32'(c - CHAR_ZERO);
               glyph_height = sum[HEIGHT_W-1:0];
               if (glyph_height <= DIGIT_TWO_MAX)
                  escape_phase = ESC_DIGIT;
               return;
            end
            if (c == CHAR_LOWER_B) begin
               bold_on = ~bold_on;
               return;
            end
            if (c == CHAR_LOWER_V) begin
               inverse_on = ~inverse_on;
               return;
            end
         end else if (escape_phase == ESC_DIGIT) begin
            escape_phase = ESC_NONE;
            if (is_digit) begin
               sum          = 32'(glyph_height) * 32'd10 + 32'(c - CHAR_ZERO);
               glyph_height = sum[HEIGHT_W-1:0];
               return;
            end
         end

         if (c == CHAR_NUL) begin
            push_result(1'b1, CHAR_NUL, 1'b0);
            bold_on      = 1'b0;
            inverse_on   = 1'b0;
            glyph_height = default_height;
            tab_count    = '0;
            escape_phase = ESC_NONE;
            in_run       = 1'b0;
            return;
         end

         if (c <= CHAR_TEXT_LOW || c >= CHAR_SPACE) begin
            push_result(1'b0, c, ~in_run);
            in_run = 1'b1;
            return;
         end

         in_run = 1'b0;
         case (c)
            CHAR_BS: begin
               bold_on = ~bold_on;
            end
            CHAR_TAB: begin
               if (tab_count < TAB_CAP)
                  tab_count = tab_count + TABS_W'(1);
            end
            CHAR_VT: begin
               inverse_on = ~inverse_on;
            end
            CHAR_FF: begin
               escape_phase = ESC_OPEN;
            end
            default: begin
               push_result(1'b0, c, 1'b1);
            end
         endcase
      endfunction

      task report(input string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_field(input string name, input int unsigned got, input int unsigned want);
         if (got != want)
            report($sformatf("%s got %0d expected %0d", name, got, want));
      endtask

      task check_result(input result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result code %h with nothing expected", got.out_code));
            return;
         end
         want = expected_q.pop_front();
         check_field("is_line_end", got.is_line_end, want.is_line_end);
         check_field("out_code", got.out_code, want.out_code);
         check_field("chunk_start", got.chunk_start, want.chunk_start);
         check_field("out_height", got.out_height, want.out_height);
         check_field("out_bold", got.out_bold, want.out_bold);
         check_field("out_inverse", got.out_inverse, want.out_inverse);
         check_field("out_tabs", got.out_tabs, want.out_tabs);
      endtask
   endclass

   logic                clock;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   logic [CODE_W-1:0]   req_code    = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   logic                rsp_is_line_end;
   logic [CODE_W-1:0]   rsp_out_code;
   logic                rsp_chunk_start;
   logic [HEIGHT_W-1:0] rsp_out_height;
   logic                rsp_out_bold;
   logic                rsp_out_inverse;
   logic [TABS_W-1:0]   rsp_out_tabs;
   logic                csr_wr_en   = 1'b0;
   logic [HEIGHT_W-1:0] csr_wr_data = '0;

   chunk_scoreboard     sb;
   int unsigned         cycle_count = 0;
   int unsigned         sent_count  = 0;
   int unsigned         idle_pct    = 0;
   int unsigned         stall_pct   = 0;

   text_markup_chunk_parser_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_code        (req_code),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_is_line_end (rsp_is_line_end),
      .rsp_out_code    (rsp_out_code),
      .rsp_chunk_start (rsp_chunk_start),
      .rsp_out_height  (rsp_out_height),
      .rsp_out_bold    (rsp_out_bold),
      .rsp_out_inverse (rsp_out_inverse),
      .rsp_out_tabs    (rsp_out_tabs),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("text_markup_chunk_parser_unit regression: fail");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_byte(req_code);
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.is_line_end = rsp_is_line_end;
         got.out_code    = rsp_out_code;
         got.chunk_start = rsp_chunk_start;
         got.out_height  = rsp_out_height;
         got.out_bold    = rsp_out_bold;
         got.out_inverse = rsp_out_inverse;
         got.out_tabs    = rsp_out_tabs;
         sb.check_result(got);
      end
   end

   task automatic send_byte(input logic [CODE_W-1:0] c);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_code  <= c;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0)
         @(negedge clock);
      // let bytes that produce no result clear the pipeline
      repeat (4) @(negedge clock);
   endtask

   task automatic write_default_height(input logic [HEIGHT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_default_height(value);
   endtask

   function automatic logic [CODE_W-1:0] random_text();
      if ($urandom_range(0, 99) < 10)
         return CODE_W'($urandom_range(1, 6));
      return CODE_W'($urandom_range(32, 255));
   endfunction

   function automatic logic [CODE_W-1:0] random_control();
      logic [CODE_W-1:0] c;
      do
         c = CODE_W'($urandom_range(7, 31));
      while (c == CHAR_BS || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF);
      return c;
   endfunction

   function automatic logic [CODE_W-1:0] random_digit(input int unsigned hi);
      return CHAR_ZERO + CODE_W'($urandom_range(0, hi));
   endfunction

   task automatic send_line(input bit tab_heavy);
      int unsigned n;
      int unsigned pick;
      n = $urandom_range(0, 18);
      if (tab_heavy)
         repeat ($urandom_range(14, 20)) send_byte(CHAR_TAB);
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 38) begin
            send_byte(random_text());
         end else if (pick < 46) begin
            send_byte(random_control());
         end else if (pick < 52) begin
            send_byte(CHAR_BS);
         end else if (pick < 58) begin
            send_byte(CHAR_VT);
         end else if (pick < 66) begin
            send_byte(CHAR_TAB);
         end else if (pick < 70) begin
            send_byte(CHAR_FF);
            send_byte(CHAR_LOWER_B);
         end else if (pick < 74) begin
            send_byte(CHAR_FF);
            send_byte(CHAR_LOWER_V);
         end else if (pick < 80) begin
            send_byte(CHAR_FF);
            send_byte(random_digit(9));
         end else if (pick < 86) begin
            send_byte(CHAR_FF);
            send_byte(random_digit(2));
            send_byte(random_digit(9));
         end else if (pick < 90) begin
            send_byte(CHAR_FF);
            send_byte(CODE_W'($urandom_range(0, 255)));
         end else if (pick < 93) begin
            send_byte(CHAR_FF);
            send_byte(random_digit(2));
            send_byte(CODE_W'($urandom_range(0, 255)));
         end else begin
            send_byte(CODE_W'($urandom_range(0, 255)));
         end
      end
      if ($urandom_range(0, 99) < 90)
         send_byte(CHAR_NUL);
   endtask

   initial begin
      logic [CODE_W-1:0]   opening_line [29];
      logic [HEIGHT_W-1:0] heights [8];
      int unsigned         phase_end;

      opening_line = '{8'h41, 8'h01, 8'h06, 8'hFF, 8'h80, 8'h07, 8'h1F,
                       CHAR_BS, 8'h42, CHAR_VT, CHAR_TAB,
                       CHAR_FF, CHAR_LOWER_B, CHAR_FF, CHAR_LOWER_V, 8'h56,
                       CHAR_FF, 8'h32, CHAR_NINE, 8'h48,
                       CHAR_FF, CHAR_ZERO, 8'h7A,
                       CHAR_FF, 8'h37, 8'h35,
                       CHAR_FF, 8'h71, CHAR_NUL};
      heights = '{5'd0, 5'd31, 5'd29, 5'd30, 5'd1, 5'd15, 5'd8, 5'd0};
      heights[7] = HEIGHT_W'($urandom_range(0, 31));

      sb = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (opening_line[i])
         send_byte(opening_line[i]);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         write_default_height(heights[ph]);
         case (ph % 4)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 66;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 66;
            end
            default: begin
               idle_pct  = 8;
               stall_pct = 8;
            end
         endcase
         phase_end = sent_count + PHASE_ITEMS;
         while (sent_count < phase_end)
            send_line($urandom_range(0, 99) < 10);
         drain();
      end

      if (sb.pending() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending()));
      if (sb.errors == 0) begin
         $display("text_markup_chunk_parser_unit regression: pass");
      end else begin
         $display("text_markup_chunk_parser_unit regression: fail");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/tmcp_pkg.sv
src/tmcp_core.sv
src/tmcp_out.sv
src/text_markup_chunk_parser_unit.sv
test/tb_text_markup_chunk_parser_unit.sv
